[rtl/core/dsot_pkg.sv]
// Package with widths, codes and control structs shared by the order table modules.
`timescale 1ns / 1ps
`default_nettype none
package dsot_pkg;
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int DATE_W = 27;
    localparam int CODE_W = 24;
    localparam int PRIO_W = 8;
    localparam int REC_W  = 16;
    localparam logic [PRIO_W-1:0] PROMOTE_PRIO = PRIO_W'(1);

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_SETPRIO = 2'd1,
        ACT_PROMOTE = 2'd2,
        ACT_DUMP    = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [REC_W-1:0]  rec;
    } t_entry;

    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic insert;
        logic set_prio;
        logic rotate;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_end;
        logic idx_last;
        logic date_le;
        logic code_eq;
        logic prio_one;
    } t_sts;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    use_data;
        logic    last;
    } t_emit;
endpackage
`default_nettype wire

[rtl/core/dsot_dp.sv]
// Datapath holding the sorted entry table, the entry count and the walk index.
`timescale 1ns / 1ps
`default_nettype none
module dsot_dp #(
    parameter int TABLE_DEPTH = dsot_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dsot_pkg::t_cmd  i_cmd,
    input  wire dsot_pkg::t_entry i_new,
    output dsot_pkg::t_sts       o_sts,
    output dsot_pkg::t_entry     o_cur
);
    import dsot_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    t_entry          r_tab [TABLE_DEPTH];
    t_entry          r_new;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    t_entry          cur;

    assign cur   = r_tab[r_idx[AW-1:0]];
    assign o_cur = cur;

    assign o_sts.full     = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.idx_end  = (r_idx == r_count);
    assign o_sts.idx_last = ((r_idx + CW'(1)) == r_count);
    assign o_sts.date_le  = (cur.date <= r_new.date);
    assign o_sts.code_eq  = (cur.code == r_new.code);
    assign o_sts.prio_one = (cur.prio == PROMOTE_PRIO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.insert) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new <= i_new;
        end
        if (i_cmd.set_prio) begin
            r_tab[r_idx[AW-1:0]].prio <= r_new.prio;
        end
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (i_cmd.insert) begin
                if (CW'(j) == r_idx) begin
                    r_tab[j] <= r_new;
                end else if (j > 0 && CW'(j) > r_idx && CW'(j) <= r_count) begin
                    r_tab[j] <= r_tab[(j > 0) ? j - 1 : 0];
                end
            end else if (i_cmd.rotate) begin
                if (j == 0) begin
                    r_tab[j] <= cur;
                end else if (CW'(j) <= r_idx) begin
                    r_tab[j] <= r_tab[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/dsot_ctrl.sv]
// Controller state machine that sequences table walks and result beats.
`timescale 1ns / 1ps
`default_nettype none
module dsot_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [dsot_pkg::ACT_W-1:0] i_action,
    input  wire logic                       i_out_free,
    input  wire dsot_pkg::t_sts             i_sts,
    output logic                            o_idle,
    output dsot_pkg::t_cmd                  o_cmd,
    output dsot_pkg::t_emit                 o_emit
);
    import dsot_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DUMP, S_DONE} t_state;

    t_state  r_state, n_state;
    t_action r_action, n_action;
    t_status r_status, n_status;

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_status = r_status;
        o_cmd    = '0;
        o_emit   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_action      = t_action'(i_action);
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                case (r_action)
                    ACT_INSERT: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (i_sts.idx_end || !i_sts.date_le) begin
                            o_cmd.insert = 1'b1;
                            n_status     = ST_OK;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    ACT_SETPRIO: begin
                        if (i_sts.idx_end) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else if (i_sts.code_eq) begin
                            o_cmd.set_prio = 1'b1;
                            n_status       = ST_OK;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    ACT_PROMOTE: begin
                        if (i_sts.idx_end) begin
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.rotate  = i_sts.prio_one;
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_DUMP;
                        end
                    end
                endcase
            end
            S_DUMP: begin
                if (i_out_free) begin
                    o_emit.valid    = 1'b1;
                    o_emit.status   = ST_OK;
                    o_emit.use_data = 1'b1;
                    o_emit.last     = i_sts.idx_last;
                    o_cmd.idx_inc   = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.status = r_status;
                    o_emit.last   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_action <= ACT_INSERT;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
            r_status <= n_status;
        end
    end
endmodule
`default_nettype wire

[rtl/core/date_sorted_order_table.sv]
// Date-sorted order table with insert, set priority, promote and dump.
// A beat is taken while idle, then the entries are walked one by one (up to TABLE_DEPTH).
// Insert, set priority and promote each walk the table and then return one status beat.
// Dump emits one beat per cycle per entry while the output is not stalled.
// One item is in work at a time; the walk over the entry registers sets the rate.
// Synchronous active-low reset empties the table and clears the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module date_sorted_order_table #(
    parameter int TABLE_DEPTH = dsot_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [dsot_pkg::ACT_W-1:0]  i_action,
    input  wire logic [dsot_pkg::DATE_W-1:0] i_entry_date,
    input  wire logic [dsot_pkg::CODE_W-1:0] i_entry_code,
    input  wire logic [dsot_pkg::PRIO_W-1:0] i_entry_priority,
    input  wire logic [dsot_pkg::REC_W-1:0]  i_record_ref,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [dsot_pkg::STAT_W-1:0]      o_status,
    output logic [dsot_pkg::DATE_W-1:0]      o_out_date,
    output logic [dsot_pkg::CODE_W-1:0]      o_out_code,
    output logic [dsot_pkg::PRIO_W-1:0]      o_out_priority,
    output logic [dsot_pkg::REC_W-1:0]       o_out_record,
    output logic                             o_last
);
    import dsot_pkg::*;

    t_cmd   cmd;
    t_sts   sts;
    t_emit  emit;
    t_entry cur;
    t_entry new_entry;
    logic   idle;
    logic   out_free;

    logic                r_valid;
    logic [STAT_W-1:0]   r_status;
    t_entry              r_data;
    logic                r_last;

    assign new_entry = '{date: i_entry_date, code: i_entry_code,
                         prio: i_entry_priority, rec: i_record_ref};
    assign out_free   = !r_valid || !i_out_stall;
    assign o_in_stall = !idle;

    dsot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_idle     (idle),
        .o_cmd      (cmd),
        .o_emit     (emit)
    );

    dsot_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_new   (new_entry),
        .o_sts   (sts),
        .o_cur   (cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit.valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_status <= emit.status;
            r_data   <= emit.use_data ? cur : '0;
            r_last   <= emit.last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_status;
    assign o_out_date     = r_data.date;
    assign o_out_code     = r_data.code;
    assign o_out_priority = r_data.prio;
    assign o_out_record   = r_data.rec;
    assign o_last         = r_last;

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sts.full && sts.empty))
        else $error("Table reports full and empty at once.");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_last)
        else $error("Error beat without last.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input taken again right after a beat.");
endmodule
`default_nettype wire
